>>> src/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 11;

    localparam logic [CNT_W-1:0]  CAP_RESET  = 11'd1024;
    localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_REPORT     = 3'd4
    } cdq_action_t;

    typedef struct packed {
        logic             ok;
        logic             is_empty;
        logic             is_full;
        logic [CNT_W-1:0] occupancy;
    } cdq_status_t;

endpackage

`default_nettype wire

>>> src/circular_deque_core.sv
`default_nettype none

// Double-ended queue of signed 32-bit words in one block RAM of MAX_DEPTH
// words. A request is taken when start is high and busy is low; it passes
// through the read state to the response state, where its result shows with
// done high for exactly one cycle; the receiver cannot stall it. Front and
// rear words come from the RAM (registered read ports), read in the cycle after
// the update is written (no request is taken then), and start may be held high
// while done is shown. The capacity register may only be written
// while no request is in flight; it defaults to 1024, zero acts as one and
// values above MAX_DEPTH saturate. An empty queue reports -1 for both words.
module circular_deque_core #(
    parameter int unsigned MAX_DEPTH = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [2:0]          action,
    input  wire logic signed [31:0]  value,
    input  wire logic                capacity_we,
    input  wire logic [10:0]         capacity,
    output logic                     done,
    output logic                     ok,
    output logic signed [31:0]       front_value,
    output logic signed [31:0]       rear_value,
    output logic                     is_empty,
    output logic                     is_full,
    output logic [10:0]              occupancy
);
    import cdq_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_DEPTH);

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_front_addr;
    logic [IDX_W-1:0]  rd_rear_addr;
    logic [WORD_W-1:0] rd_front_data;
    logic [WORD_W-1:0] rd_rear_data;
    cdq_status_t       status;

    cdq_ctrl #(
        .MAX_DEPTH (MAX_DEPTH),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .action        (action),
        .value         (value),
        .capacity_we   (capacity_we),
        .capacity      (capacity),
        .busy          (busy),
        .done          (done),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_front_addr (rd_front_addr),
        .rd_rear_addr  (rd_rear_addr),
        .status        (status)
    );

    cdq_store #(
        .DEPTH (MAX_DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk           (clk),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_front_addr (rd_front_addr),
        .rd_rear_addr  (rd_rear_addr),
        .rd_front_data (rd_front_data),
        .rd_rear_data  (rd_rear_data)
    );

    assign ok          = status.ok;
    assign is_empty    = status.is_empty;
    assign is_full     = status.is_full;
    assign occupancy   = status.occupancy;
    assign front_value = status.is_empty ? EMPTY_WORD : rd_front_data;
    assign rear_value  = status.is_empty ? EMPTY_WORD : rd_rear_data;

endmodule

`default_nettype wire

>>> src/cdq_store.sv
`default_nettype none

module cdq_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned IDX_W = 10
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [IDX_W-1:0]         wr_addr,
    input  wire logic [cdq_pkg::WORD_W-1:0] wr_data,
    input  wire logic                     rd_en,
    input  wire logic [IDX_W-1:0]         rd_front_addr,
    input  wire logic [IDX_W-1:0]         rd_rear_addr,
    output logic      [cdq_pkg::WORD_W-1:0] rd_front_data,
    output logic      [cdq_pkg::WORD_W-1:0] rd_rear_data
);
    import cdq_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_front_reg;
    logic [WORD_W-1:0] rd_rear_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Both read ports are registered; reads are never issued in the write cycle.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_front_reg <= mem[rd_front_addr];
            rd_rear_reg  <= mem[rd_rear_addr];
        end
    end

    assign rd_front_data = rd_front_reg;
    assign rd_rear_data  = rd_rear_reg;

endmodule

`default_nettype wire

>>> src/cdq_ctrl.sv
`default_nettype none

module cdq_ctrl #(
    parameter int unsigned MAX_DEPTH = 1024,
    parameter int unsigned IDX_W     = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [2:0]                 action,
    input  wire logic [cdq_pkg::WORD_W-1:0] value,
    input  wire logic                       capacity_we,
    input  wire logic [cdq_pkg::CNT_W-1:0]  capacity,
    output logic                            busy,
    output logic                            done,
    output logic                            wr_en,
    output logic      [IDX_W-1:0]           wr_addr,
    output logic      [cdq_pkg::WORD_W-1:0] wr_data,
    output logic                            rd_en,
    output logic      [IDX_W-1:0]           rd_front_addr,
    output logic      [IDX_W-1:0]           rd_rear_addr,
    output cdq_pkg::cdq_status_t            status
);
    import cdq_pkg::*;

    localparam int unsigned CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_RESP = 3'b100
    } cdq_state_t;

    cdq_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  capacity_reg;
    cdq_status_t       status_reg, status_next;

    logic [CMP_W-1:0]  eff_cap;
    logic              accept;
    logic              cur_empty;
    logic              cur_full;
    logic              ok_c;
    logic              push_front_c;

    function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i,
                                                input logic [CMP_W-1:0] cap);
        logic [CMP_W-1:0] inc;
        inc = CMP_W'(i) + CMP_W'(1);
        return (inc >= cap) ? '0 : inc[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i,
                                                  input logic [CMP_W-1:0] cap);
        logic [CMP_W-1:0] top;
        top = cap - CMP_W'(1);
        return (i == '0) ? top[IDX_W-1:0] : i - IDX_W'(1);
    endfunction

    // A capacity of zero acts as one; anything beyond the built depth saturates.
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(capacity_reg) > CMP_W'(MAX_DEPTH))
        begin
            eff_cap = CMP_W'(MAX_DEPTH);
        end
        else
        begin
            eff_cap = CMP_W'(capacity_reg);
        end
    end

    assign busy      = (state_reg == ST_READ);
    assign accept    = start && !busy;
    assign cur_empty = (count_reg == '0);
    assign cur_full  = (CMP_W'(count_reg) >= eff_cap);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        ok_c         = 1'b0;
        push_front_c = 1'b0;
        unique case (cdq_action_t'(action))
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                push_front_c = (cdq_action_t'(action) == ACT_PUSH_FRONT);
                if (!cur_full)
                begin
                    if (cur_empty)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else if (push_front_c)
                    begin
                        head_next = idx_down(head_reg, eff_cap);
                    end
                    else
                    begin
                        tail_next = idx_up(tail_reg, eff_cap);
                    end
                    count_next = count_reg + CNT_W'(1);
                    ok_c       = 1'b1;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (!cur_empty)
                begin
                    if (count_reg == CNT_W'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else if (cdq_action_t'(action) == ACT_POP_FRONT)
                    begin
                        head_next = idx_up(head_reg, eff_cap);
                    end
                    else
                    begin
                        tail_next = idx_down(tail_reg, eff_cap);
                    end
                    count_next = count_reg - CNT_W'(1);
                    ok_c       = 1'b1;
                end
            end
            ACT_REPORT:
            begin
                ok_c = 1'b1;
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        status_next.ok        = ok_c;
        status_next.is_empty  = (count_next == '0);
        status_next.is_full   = (CMP_W'(count_next) >= eff_cap);
        status_next.occupancy = count_next;
    end

    // The word is written in the transfer cycle; both ends are read in the next one.
    assign wr_en   = accept && ok_c
                     && (cdq_action_t'(action) == ACT_PUSH_FRONT
                         || cdq_action_t'(action) == ACT_PUSH_BACK);
    assign wr_addr = push_front_c ? head_next : tail_next;
    assign wr_data = value;

    assign rd_en         = busy;
    assign rd_front_addr = head_reg;
    assign rd_rear_addr  = tail_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = accept ? ST_READ : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            if (capacity_we)
            begin
                capacity_reg <= capacity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    assign done   = (state_reg == ST_RESP);
    assign status = status_reg;

endmodule

`default_nettype wire

>>> src/cdq_checker.sv
`default_nettype none

module cdq_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic signed [31:0] front_value,
    input wire logic signed [31:0] rear_value,
    input wire logic               is_empty,
    input wire logic               is_full,
    input wire logic [10:0]        occupancy
);

    // Every transfer in is followed by one busy cycle and then its result.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("no busy cycle after a request transfer");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("result did not follow the busy cycle");

    a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |->
            (front_value == -32'sd1 && rear_value == -32'sd1 && occupancy == 11'd0))
        else $error("empty queue reported words or a nonzero count");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_full) |-> (!is_empty && occupancy != 11'd0))
        else $error("queue reported full and empty together");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (.*);

`default_nettype wire

>>> sim/tb_circular_deque_core.sv
`default_nettype none

module tb_circular_deque_core;
    import cdq_pkg::*;

    localparam int unsigned DEPTH        = 1024;
    localparam int unsigned MAX_REPORTED = 10;
    localparam int unsigned PHASES       = 12;
    localparam int unsigned PHASE_ITEMS  = 85;

    // Slots 0..PREFIX_SLOTS-1 are all written early. The capacity only changes
    // with entries held while it stays within this prefix, so the ends never
    // land on a slot that was never written.
    localparam int unsigned PREFIX_SLOTS = 64;

    // Action codes outside the defined set; the block must leave its state alone.
    localparam logic [2:0] ACT_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNKNOWN_MID   = 3'd6;
    localparam logic [2:0] ACT_UNKNOWN_LAST  = 3'd7;

    localparam logic [CNT_W-1:0] CAP_PLAN [PHASES] = '{
        11'd0, 11'd1, 11'd2, 11'd3, 11'd5, 11'd17,
        11'd64, 11'd1023, 11'd1000, 11'd1024, 11'd2047, 11'd9
    };
    localparam int unsigned PUSH_PLAN [PHASES] = '{
        50, 60, 55, 50, 60, 65, 85, 70, 40, 60, 50, 55
    };

    typedef struct packed {
        logic [2:0]        act;
        logic [WORD_W-1:0] word;
    } deque_req_t;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] front;
        logic [WORD_W-1:0] rear;
        logic              empty;
        logic              full;
        logic [CNT_W-1:0]  occ;
    } deque_view_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [2:0]               action = '0;
    logic signed [WORD_W-1:0] value = '0;
    logic                     capacity_we = 1'b0;
    logic [CNT_W-1:0]         capacity = '0;
    logic                     done;
    logic                     ok;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic [CNT_W-1:0]         occupancy;

    // Shadow copy of the deque contents and its capacity register.
    logic [WORD_W-1:0] shadow_slot [DEPTH];
    int unsigned       shadow_head = 0;
    int unsigned       shadow_tail = 0;
    int unsigned       shadow_count = 0;
    logic [CNT_W-1:0]  shadow_cap = CAP_RESET;

    deque_req_t  request_queue [$];
    deque_view_t expected_views [$];
    int unsigned gap_left = 0;
    bit          sender_gaps = 1'b1;
    int unsigned fail_count = 0;

    circular_deque_core #(
        .MAX_DEPTH(DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .value      (value),
        .capacity_we(capacity_we),
        .capacity   (capacity),
        .done       (done),
        .ok         (ok),
        .front_value(front_value),
        .rear_value (rear_value),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .occupancy  (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned live_capacity();
        int unsigned c;
        c = shadow_cap;
        if (c == 0)
            c = 1;
        if (c > DEPTH)
            c = DEPTH;
        return c;
    endfunction

    // Applies one request to the shadow deque and returns the status it leaves.
    function automatic deque_view_t step_shadow(input deque_req_t req);
        int unsigned cap;
        deque_view_t view;
        cap = live_capacity();
        view = '0;
        case (req.act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (shadow_count < cap)
                begin
                    if (shadow_count == 0)
                    begin
                        shadow_head = 0;
                        shadow_tail = 0;
                    end
                    else if (req.act == ACT_PUSH_FRONT)
                        shadow_head = (shadow_head == 0) ? cap - 1 : shadow_head - 1;
                    else
                        shadow_tail = (shadow_tail + 1 >= cap) ? 0 : shadow_tail + 1;
                    if (req.act == ACT_PUSH_FRONT)
                        shadow_slot[shadow_head] = req.word;
                    else
                        shadow_slot[shadow_tail] = req.word;
                    shadow_count++;
                    view.ok = 1'b1;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (shadow_count != 0)
                begin
                    if (shadow_count == 1)
                    begin
                        shadow_head = 0;
                        shadow_tail = 0;
                    end
                    else if (req.act == ACT_POP_FRONT)
                        shadow_head = (shadow_head + 1 >= cap) ? 0 : shadow_head + 1;
                    else
                        shadow_tail = (shadow_tail == 0) ? cap - 1 : shadow_tail - 1;
                    shadow_count--;
                    view.ok = 1'b1;
                end
            end
            ACT_REPORT:
                view.ok = 1'b1;
            default:
                ;
        endcase
        view.empty = (shadow_count == 0);
        view.full  = (shadow_count >= cap);
        view.front = view.empty ? EMPTY_WORD : shadow_slot[shadow_head];
        view.rear  = view.empty ? EMPTY_WORD : shadow_slot[shadow_tail];
        view.occ   = CNT_W'(shadow_count);
        return view;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!sender_gaps || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Request driver: a request stays on the ports until its transfer completes.
    always @(posedge clk or negedge rst_n)
    begin
        deque_req_t taken;
        deque_req_t next_req;
        if (!rst_n)
        begin
            start    <= 1'b0;
            action   <= '0;
            value    <= '0;
            gap_left <= 0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                taken.act  = action;
                taken.word = value;
                expected_views.push_back(step_shadow(taken));
            end
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (request_queue.size() != 0)
            begin
                next_req = request_queue.pop_front();
                action   <= next_req.act;
                value    <= next_req.word;
                start    <= 1'b1;
                gap_left <= pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        deque_view_t want;
        deque_view_t got;
        if (rst_n && done)
        begin
            got = {ok, front_value, rear_value, is_empty, is_full, occupancy};
            if (expected_views.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTED)
                    $display("ERROR: result with none expected: ok=%0b front=%0d rear=%0d",
                             got.ok, $signed(got.front), $signed(got.rear));
            end
            else
            begin
                want = expected_views.pop_front();
                if (got.ok !== want.ok || got.front !== want.front || got.rear !== want.rear
                    || got.empty !== want.empty || got.full !== want.full
                    || got.occ !== want.occ)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTED)
                    begin
                        $display("ERROR: exp ok=%0b front=%0d rear=%0d empty=%0b full=%0b occ=%0d",
                                 want.ok, $signed(want.front), $signed(want.rear),
                                 want.empty, want.full, want.occ);
                        $display("       got ok=%0b front=%0d rear=%0d empty=%0b full=%0b occ=%0d",
                                 got.ok, $signed(got.front), $signed(got.rear),
                                 got.empty, got.full, got.occ);
                    end
                end
            end
        end
    end

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 39))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(input logic [2:0] act, input logic [WORD_W-1:0] word);
        deque_req_t req;
        req.act  = act;
        req.word = word;
        request_queue.push_back(req);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || start || expected_views.size() != 0);
    endtask

    // Pops every entry held so the next capacity change happens on an empty queue.
    task automatic drain_all();
        int unsigned held;
        wait_drained();
        held = shadow_count;
        for (int unsigned i = 0; i < held; i++)
            queue_item($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK, random_word());
        wait_drained();
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        repeat (3) @(negedge clk);
        @(posedge clk);
        capacity_we <= 1'b1;
        capacity    <= cap;
        shadow_cap = cap;
        @(posedge clk);
        capacity_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_random_phase(input int unsigned count, input int unsigned push_pct);
        int unsigned r;
        for (int unsigned i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                queue_item(3'($urandom_range(ACT_UNKNOWN_FIRST, ACT_UNKNOWN_LAST)),
                           random_word());
            else if (r < 12)
                queue_item(ACT_REPORT, random_word());
            else if (r < 12 + push_pct * 88 / 100)
                queue_item($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                           random_word());
            else
                queue_item($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK,
                           random_word());
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty-queue behavior, refused pops, unknown actions and value extremes.
        queue_item(ACT_REPORT, random_word());
        queue_item(ACT_POP_FRONT, random_word());
        queue_item(ACT_POP_BACK, random_word());
        queue_item(ACT_UNKNOWN_FIRST, random_word());
        queue_item(ACT_UNKNOWN_MID, random_word());
        queue_item(ACT_UNKNOWN_LAST, random_word());
        queue_item(ACT_PUSH_FRONT, 32'h8000_0000);
        queue_item(ACT_PUSH_BACK, 32'h7FFF_FFFF);
        queue_item(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        queue_item(ACT_PUSH_BACK, 32'h0000_0000);
        queue_item(ACT_UNKNOWN_LAST, random_word());
        queue_item(ACT_REPORT, random_word());
        queue_item(ACT_POP_BACK, random_word());
        queue_item(ACT_POP_FRONT, random_word());
        queue_item(ACT_POP_BACK, random_word());
        queue_item(ACT_POP_FRONT, random_word());
        queue_item(ACT_POP_FRONT, random_word());
        queue_item(ACT_PUSH_BACK, 32'h5A5A_A5A5);
        queue_item(ACT_POP_BACK, random_word());
        wait_drained();

        // Fill the prefix completely, then try to push into the full queue.
        write_capacity(CNT_W'(PREFIX_SLOTS));
        sender_gaps = 1'b0;
        for (int unsigned i = 0; i < PREFIX_SLOTS; i++)
            queue_item(ACT_PUSH_BACK, random_word());
        queue_item(ACT_PUSH_FRONT, random_word());
        queue_item(ACT_PUSH_BACK, random_word());
        queue_item(ACT_REPORT, random_word());
        wait_drained();

        // Shrink the capacity far below the number of entries held.
        sender_gaps = 1'b1;
        write_capacity(11'd2);
        run_random_phase(60, 50);
        wait_drained();
        sender_gaps = 1'b0;
        drain_all();

        for (int unsigned k = 0; k < PHASES; k++)
        begin
            if (CAP_PLAN[k] > PREFIX_SLOTS || shadow_cap > PREFIX_SLOTS)
                drain_all();
            write_capacity(CAP_PLAN[k]);
            sender_gaps = (k % 3 != 0);
            run_random_phase(PHASE_ITEMS, PUSH_PLAN[k]);
            wait_drained();
        end

        sender_gaps = 1'b1;
        write_capacity(CNT_W'($urandom_range(1, 40)));
        run_random_phase(PHASE_ITEMS, $urandom_range(35, 75));
        wait_drained();

        repeat (5) @(posedge clk);
        fail_count += expected_views.size();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
